### rtl/ssms_pkg.sv
// Package for the sorted sparse matrix store: sizes, opcodes, status codes,
// beat structs and the stored entry layout. No dependencies.
package ssms_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = 16;
  localparam int VAL_W    = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_SET    = 2'd1,
    OP_READ   = 2'd2,
    OP_DUMP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_NO_MATRIX  = 2'd2,
    STAT_FULL       = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         column_index;
    logic signed [VAL_W-1:0]  entry_value;
  } in_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_column;
    logic signed [VAL_W-1:0]  out_value;
    status_t                  status;
    logic                     last;
  } out_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic out_beat_t mk_result(input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input logic signed [VAL_W-1:0] value,
                                          input status_t st,
                                          input logic lst);
    out_beat_t b;
    b.out_row    = row;
    b.out_column = col;
    b.out_value  = value;
    b.status     = st;
    b.last       = lst;
    return b;
  endfunction

endpackage

### rtl/ssms_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ssms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

### rtl/sorted_sparse_matrix_store_unit.sv
// Top level of the sorted sparse matrix store: sequencer around one entry RAM.
// Depends on ssms_pkg and ssms_ram.
//
//  channel | ports                      | beat
//  --------+----------------------------+------------------------------------
//  input   | in_valid, in_stall, in_data   | opcode, row, column, value
//  output  | out_valid, out_stall, out_data| row, column, value, status, last
//
// Create completes in the idle state. Set/read scan the table one entry per
// cycle through the RAM read port; a read or an error then yields a result
// beat, and an insert shifts the tail one entry per cycle and then places the
// new entry. Dump scans the stored entries one per cycle unless an output
// stall holds it. Reset clears state, count, matrix flag, pending flag and
// output valid; RAM contents need no clearing.
// An output stall holds the sequencer wherever it must hand over a beat.
module sorted_sparse_matrix_store_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ssms_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ssms_pkg::out_beat_t out_data
);
  import ssms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PLACE,
    S_RESULT
  } state_t;

  state_t                  state_r, state_nxt;
  in_beat_t                item_r, item_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    present_r, present_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic                    match_r, match_nxt;
  logic signed [VAL_W-1:0] hit_val_r, hit_val_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  entry_t                  pend_r, pend_nxt;
  out_beat_t               res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_data_r, out_data_nxt;

  logic               wr_en, rd_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [ENTRY_W-1:0] wr_data, rd_data;
  entry_t             rd_entry, new_entry;

  logic               out_free, push, nz;
  out_beat_t          push_data;
  logic [CNT_W-1:0]   idx_inc, idx_dec, cnt_dec;
  logic [2*IDX_W-1:0] entry_key, item_key;

  ssms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  assign rd_entry  = entry_t'(rd_data);
  assign new_entry = '{row: item_r.row_index, col: item_r.column_index,
                       value: item_r.entry_value};
  assign entry_key = {rd_entry.row, rd_entry.col};
  assign item_key  = {item_r.row_index, item_r.column_index};
  assign idx_inc   = idx_r + CNT_W'(1);
  assign idx_dec   = idx_r - CNT_W'(1);
  assign cnt_dec   = count_r - CNT_W'(1);
  assign nz        = (rd_entry.value != '0);

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    count_nxt      = count_r;
    present_nxt    = present_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    match_nxt      = match_r;
    hit_val_nxt    = hit_val_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    res_nxt        = res_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_addr        = '0;
    push           = 1'b0;
    push_data      = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          unique case (in_data.opcode)
            OP_CREATE: begin
              count_nxt   = '0;
              present_nxt = 1'b1;
            end
            OP_DUMP: begin
              pend_valid_nxt = 1'b0;
              if (present_r) begin
                if (count_r == '0) begin
                  res_nxt   = mk_result('0, '0, '0, STAT_EMPTY, 1'b1);
                  state_nxt = S_RESULT;
                end else begin
                  rd_en     = 1'b1;
                  idx_nxt   = '0;
                  state_nxt = S_SCAN;
                end
              end
            end
            OP_SET, OP_READ: begin
              if (!present_r) begin
                res_nxt   = mk_result(in_data.row_index, in_data.column_index, '0,
                                      STAT_NO_MATRIX, 1'b1);
                state_nxt = S_RESULT;
              end else if (count_r == '0) begin
                pos_nxt   = '0;
                match_nxt = 1'b0;
                state_nxt = S_DECIDE;
              end else begin
                rd_en     = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (item_r.opcode == OP_DUMP) begin
          // one result held back so the final one can carry last
          if (!(nz && pend_valid_r && !out_free)) begin
            if (nz && pend_valid_r) begin
              push      = 1'b1;
              push_data = mk_result(pend_r.row, pend_r.col, pend_r.value, STAT_OK, 1'b0);
            end
            if (nz) begin
              pend_nxt       = rd_entry;
              pend_valid_nxt = 1'b1;
            end
            if (idx_inc == count_r) begin
              if (nz) begin
                res_nxt = mk_result(rd_entry.row, rd_entry.col, rd_entry.value,
                                    STAT_OK, 1'b1);
              end else if (pend_valid_r) begin
                res_nxt = mk_result(pend_r.row, pend_r.col, pend_r.value, STAT_OK, 1'b1);
              end else begin
                res_nxt = mk_result('0, '0, '0, STAT_EMPTY, 1'b1);
              end
              state_nxt = S_RESULT;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_inc[ADDR_W-1:0];
              idx_nxt = idx_inc;
            end
          end
        end else if (entry_key >= item_key) begin
          pos_nxt     = idx_r;
          match_nxt   = (entry_key == item_key);
          hit_val_nxt = rd_entry.value;
          state_nxt   = S_DECIDE;
        end else if (idx_inc == count_r) begin
          pos_nxt   = count_r;
          match_nxt = 1'b0;
          state_nxt = S_DECIDE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[ADDR_W-1:0];
          idx_nxt = idx_inc;
        end
      end

      S_DECIDE: begin
        if (item_r.opcode == OP_READ) begin
          res_nxt   = mk_result(item_r.row_index, item_r.column_index,
                                match_r ? hit_val_r : '0, STAT_OK, 1'b1);
          state_nxt = S_RESULT;
        end else if (match_r) begin
          wr_en     = 1'b1;
          wr_addr   = pos_r[ADDR_W-1:0];
          wr_data   = new_entry;
          state_nxt = S_IDLE;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          res_nxt   = mk_result(item_r.row_index, item_r.column_index,
                                item_r.entry_value, STAT_FULL, 1'b1);
          state_nxt = S_RESULT;
        end else if (pos_r == count_r) begin
          wr_en     = 1'b1;
          wr_addr   = pos_r[ADDR_W-1:0];
          wr_data   = new_entry;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = cnt_dec[ADDR_W-1:0];
          idx_nxt   = cnt_dec;
          state_nxt = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // reads walk down from the tail, each write lands one slot above
        wr_en   = 1'b1;
        wr_addr = idx_inc[ADDR_W-1:0];
        wr_data = rd_data;
        if (idx_r == pos_r) begin
          state_nxt = S_PLACE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[ADDR_W-1:0];
          idx_nxt = idx_dec;
        end
      end

      S_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[ADDR_W-1:0];
        wr_data   = new_entry;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_IDLE;
      end

      S_RESULT: begin
        if (out_free) begin
          push      = 1'b1;
          push_data = res_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      present_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      present_r    <= present_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    match_r    <= match_nxt;
    hit_val_r  <= hit_val_nxt;
    pend_r     <= pend_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_en)
    else $error("RAM write while idle");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_inc > pos_r) && (idx_r < count_r))
    else $error("shift write outside tail");

  a_create: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.opcode == OP_CREATE)
      |=> (count_r == '0) && present_r)
    else $error("create did not empty the table");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("held result overwritten");
`endif

endmodule
